### hdl/rtac_pkg.sv
// Shared types, constants and helpers for the radix-to-ASCII converter.
// Used by every module of the block; depends on nothing else.

package rtac_pkg;

    // Value width default and the fixed widths of the payload fields.
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int NUMBER_W        = 32;
    localparam int RADIX_W         = 6;
    localparam int CHAR_W          = 8;

    // Command queue depth between front and back (power of two).
    localparam int CMD_DEPTH = 2;

    // Quotient bits resolved by the divider in one cycle.
    localparam int BITS_PER_CYCLE = 4;

    // Radix register reset value and legal range.
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_ERROR   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

    // Control part of one queued command.
    typedef struct packed {
        logic               bad;
        logic [RADIX_W-1:0] radix;
    } t_cmd_ctrl;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_SEND,
        S_ERR
    } t_back_state;

    // Map a digit value (below 36) to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_LOWER_A + CHAR_W'(d - DEC_DIGITS);
        end
        return c;
    endfunction

endpackage

### hdl/rtac_cmd_fifo.sv
// Short command queue between the front and the back of the converter.
// Depends on rtac_pkg for the default depth; width set by parameter.

module rtac_cmd_fifo
    import rtac_pkg::*;
#(
    parameter int WIDTH = 39,
    parameter int DEPTH = CMD_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill count; depth is a power of two so pointers wrap naturally.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("command queue count out of range");
`endif

endmodule

### hdl/rtac_front.sv
// Front end: holds the radix register, accepts values and classifies them.
// Depends on rtac_pkg for widths, radix limits and the command struct.

module rtac_front
    import rtac_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [RADIX_W-1:0]     i_cfg_radix,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [NUMBER_W-1:0]    i_number,
    output logic                   o_push,
    output t_cmd_ctrl              o_ctrl,
    output logic [VALUE_WIDTH-1:0] o_value,
    input  logic                   i_full
);

    logic [RADIX_W-1:0] r_radix;

    // Radix register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_radix;
        end
    end

    // Accept a word whenever the queue has room and tag it with the current base.
    assign o_ready      = !i_full;
    assign o_push       = i_valid && !i_full;
    assign o_ctrl.bad   = (r_radix < RADIX_MIN) || (r_radix > RADIX_MAX);
    assign o_ctrl.radix = r_radix;
    assign o_value      = VALUE_WIDTH'(i_number);

endmodule

### hdl/rtac_back.sv
// Back end: iterative divider, digit stack and output register.
// Depends on rtac_pkg for the command struct, state enum and digit mapping.

module rtac_back
    import rtac_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  t_cmd_ctrl              i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [CHAR_W-1:0]      o_character,
    output logic                   o_last,
    output logic                   o_bad_radix
);

    localparam int DIV_CYCLES = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int PAD_W      = DIV_CYCLES * BITS_PER_CYCLE;
    localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int DIG_AW     = $clog2(VALUE_WIDTH);

    t_back_state r_state, n_state;

    logic [RADIX_W-1:0] r_radix, n_radix;
    logic [RADIX_W-1:0] r_rem, n_rem;
    logic [PAD_W-1:0]   r_dvd, n_dvd;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [DIG_AW-1:0]  r_ptr, n_ptr;

    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic               r_out_last, n_out_last;
    logic               r_out_bad, n_out_bad;

    logic [CHAR_W-1:0]  r_stack [VALUE_WIDTH];
    logic [CHAR_W-1:0]  r_rd_data;

    logic [RADIX_W-1:0] w_rem_step;
    logic [PAD_W-1:0]   w_dvd_step;
    logic [RADIX_W:0]   w_trial;
    logic               w_qbit;
    logic               w_last_step;
    logic               w_out_free;
    logic               w_push_digit;

    // Restoring division, several quotient bits per cycle; quotient shifts into the dividend.
    always_comb begin
        w_rem_step = r_rem;
        w_dvd_step = r_dvd;
        w_trial    = '0;
        w_qbit     = 1'b0;
        for (int i = 0; i < BITS_PER_CYCLE; i++) begin
            w_trial = {w_rem_step, w_dvd_step[PAD_W-1]};
            if (w_trial >= {1'b0, r_radix}) begin
                w_rem_step = RADIX_W'(w_trial - {1'b0, r_radix});
                w_qbit     = 1'b1;
            end else begin
                w_rem_step = w_trial[RADIX_W-1:0];
                w_qbit     = 1'b0;
            end
            w_dvd_step = {w_dvd_step[PAD_W-2:0], w_qbit};
        end
    end

    assign w_last_step  = (r_step == STEP_W'(DIV_CYCLES - 1));
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_push_digit = (r_state == S_DIV) && w_last_step;

    // Sequencer: next state and next register values.
    always_comb begin
        n_state     = r_state;
        n_radix     = r_radix;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_step      = r_step;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid && !i_ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;
        o_pop       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_radix = i_ctrl.radix;
                    n_dvd   = PAD_W'(i_value);
                    n_rem   = '0;
                    n_step  = '0;
                    n_ptr   = '0;
                    n_state = i_ctrl.bad ? S_ERR : S_DIV;
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_ERROR;
                    n_out_last  = 1'b1;
                    n_out_bad   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DIV: begin
                n_rem  = w_rem_step;
                n_dvd  = w_dvd_step;
                n_step = r_step + STEP_W'(1);
                if (w_last_step) begin
                    // One digit done; the remainder restarts for the next digit.
                    n_rem  = '0;
                    n_step = '0;
                    if (w_dvd_step == '0) begin
                        n_state = S_READ;
                    end else begin
                        n_ptr = r_ptr + DIG_AW'(1);
                    end
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_rd_data;
                    n_out_last  = (r_ptr == '0);
                    n_out_bad   = 1'b0;
                    if (r_ptr == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr - DIG_AW'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_ptr       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_ptr       <= n_ptr;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_radix    <= n_radix;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
    end

    // Digit stack: least significant digit written first, read back from the top.
    always_ff @(posedge i_clk) begin
        if (w_push_digit) begin
            r_stack[r_ptr] <= digit_char(w_rem_step);
        end
        r_rd_data <= r_stack[r_ptr];
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;
    assign o_bad_radix = r_out_bad;

`ifndef NO_ASSERTIONS
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_radix))
        else $error("partial remainder not below radix");
    a_div_good_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX)))
        else $error("division started with an illegal radix");
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_last && (r_out_char == CHAR_ERROR)))
        else $error("error word is not a single zero character");
`endif

endmodule

### hdl/radix_to_ascii_converter_core.sv
// Top level of the radix-to-ASCII converter.
// Depends on rtac_pkg, rtac_front, rtac_cmd_fifo and rtac_back.

// Usage:
// - Configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_radix) writes the base;
//   it is always ready and should only be written while the block is idle.
// - Input channel (i_valid, o_ready, i_number) takes one unsigned value per word.
// - Output channel (o_valid, i_ready, o_character, o_last, o_bad_radix) gives the
//   ASCII digits most significant first; o_last marks the final character.
// - A base outside 2 to 36 gives one word with character zero, o_last and o_bad_radix.
// - A two-entry command queue decouples input acceptance from conversion.
// Conversion:
// - Each digit comes from the iterative divider, which resolves four quotient
//   bits per cycle; each character is then read from the digit stack and sent.
// Reset: synchronous, active low; the base returns to 10 and the queue empties.
// A stalled receiver holds the output word and the back end waits on it; input
// words are still taken until the two-entry queue is full.

module radix_to_ascii_converter_core
    import rtac_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RADIX_W-1:0]  i_cfg_radix,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [NUMBER_W-1:0] i_number,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHAR_W-1:0]   o_character,
    output logic                o_last,
    output logic                o_bad_radix
);

    localparam int CMD_W = $bits(t_cmd_ctrl) + VALUE_WIDTH;

    logic                   w_push;
    logic                   w_pop;
    logic                   w_full;
    logic                   w_empty;
    t_cmd_ctrl              w_front_ctrl;
    logic [VALUE_WIDTH-1:0] w_front_value;
    t_cmd_ctrl              w_back_ctrl;
    logic [VALUE_WIDTH-1:0] w_back_value;
    logic [CMD_W-1:0]       w_fifo_in;
    logic [CMD_W-1:0]       w_fifo_out;

    // Front end: radix register and classification.
    rtac_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_radix (i_cfg_radix),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_number    (i_number),
        .o_push      (w_push),
        .o_ctrl      (w_front_ctrl),
        .o_value     (w_front_value),
        .i_full      (w_full)
    );

    // Command queue.
    assign w_fifo_in = {w_front_ctrl, w_front_value};

    rtac_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fifo_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_fifo_out),
        .o_empty (w_empty)
    );

    assign w_back_ctrl  = w_fifo_out[CMD_W-1:VALUE_WIDTH];
    assign w_back_value = w_fifo_out[VALUE_WIDTH-1:0];

    // Back end: divider, digit stack and output register.
    rtac_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_ctrl      (w_back_ctrl),
        .i_value     (w_back_value),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last),
        .o_bad_radix (o_bad_radix)
    );

endmodule
